// ===== rtl/dssm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and constants for the dual stack shared memory block.
// ----------------------------------------------------------------------------
package dssm_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int WORD_W   = 32;
    localparam int FREE_W   = 7;
    localparam int FREE_MAX = 127;

    localparam int IN_W     = 40;
    localparam int OUT_W    = 112;
    localparam int OUT_USED = 2 + 3 * WORD_W + 2 + FREE_W;

    typedef enum logic [1:0] {
        OP_PUSH_A = 2'd0,
        OP_PUSH_B = 2'd1,
        OP_POP_A  = 2'd2,
        OP_POP_B  = 2'd3
    } dssm_op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } dssm_status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOAD = 2'd1,
        S_RESP = 2'd2
    } dssm_state_t;

    typedef struct packed {
        logic exec;
        logic load_top;
        logic load_out;
    } dssm_cmd_t;

    typedef struct packed {
        logic pop_read;
        logic out_free;
    } dssm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/dssm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_ctrl
// Sequencer: accepts one operation, waits on the top-of-stack reload after
// a pop that leaves entries, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dssm_ctrl
    import dssm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dssm_stat_t stat,
    output dssm_cmd_t       cmd
);

    dssm_state_t state_reg;
    dssm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_top = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.pop_read ? S_LOAD : S_RESP;
                end
            end
            S_LOAD:
            begin
                // new top word arrives from the array this cycle
                cmd.load_top = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dssm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_datapath
// Shared word array, depth counters, cached top words and result register.
// ----------------------------------------------------------------------------
module dssm_datapath
    import dssm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  wire dssm_cmd_t        cmd,
    output dssm_stat_t            stat
);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]  depth_a_reg;
    logic [CNT_W-1:0]  depth_a_next;
    logic [CNT_W-1:0]  depth_b_reg;
    logic [CNT_W-1:0]  depth_b_next;
    logic [WORD_W-1:0] top_a_reg;
    logic [WORD_W-1:0] top_a_next;
    logic [WORD_W-1:0] top_b_reg;
    logic [WORD_W-1:0] top_b_next;
    logic [WORD_W-1:0] popped_reg;
    logic [WORD_W-1:0] popped_next;
    dssm_status_t      status_reg;
    dssm_status_t      status_next;
    logic              side_b_reg;
    logic              side_b_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    dssm_op_t          op_in;
    logic [WORD_W-1:0] push_value;
    logic              full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              pop_read;
    logic [CNT_W-1:0]  free_full;
    logic [FREE_W-1:0] free_space;
    logic              a_is_empty;
    logic              b_is_empty;
    logic [WORD_W-1:0] top_a_value;
    logic [WORD_W-1:0] top_b_value;

    assign op_in      = dssm_op_t'(s_tdata[1:0]);
    assign push_value = s_tdata[WORD_W+1:2];
    assign full       = (SUM_W'(depth_a_reg) + SUM_W'(depth_b_reg)) >= SUM_W'(CAPACITY);

    always_comb
    begin
        depth_a_next = depth_a_reg;
        depth_b_next = depth_b_reg;
        top_a_next   = top_a_reg;
        top_b_next   = top_b_reg;
        popped_next  = '0;
        status_next  = ST_DONE;
        side_b_next  = side_b_reg;
        wr_en        = 1'b0;
        wr_addr      = depth_a_reg[ADDR_W-1:0];
        rd_addr      = ADDR_W'(depth_a_reg - CNT_W'(2));
        pop_read     = 1'b0;
        unique case (op_in)
            OP_PUSH_A:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en        = cmd.exec;
                    depth_a_next = depth_a_reg + CNT_W'(1);
                    top_a_next   = push_value;
                end
            end
            OP_PUSH_B:
            begin
                wr_addr = ADDR_W'(CNT_W'(CAPACITY - 1) - depth_b_reg);
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en        = cmd.exec;
                    depth_b_next = depth_b_reg + CNT_W'(1);
                    top_b_next   = push_value;
                end
            end
            OP_POP_A:
            begin
                if (depth_a_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next  = top_a_reg;
                    depth_a_next = depth_a_reg - CNT_W'(1);
                    side_b_next  = 1'b0;
                    pop_read     = (depth_a_reg != CNT_W'(1));
                end
            end
            OP_POP_B:
            begin
                // entry just below the current top of B
                rd_addr = ADDR_W'(CNT_W'(CAPACITY + 1) - depth_b_reg);
                if (depth_b_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next  = top_b_reg;
                    depth_b_next = depth_b_reg - CNT_W'(1);
                    side_b_next  = 1'b1;
                    pop_read     = (depth_b_reg != CNT_W'(1));
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_a_reg <= '0;
            depth_b_reg <= '0;
            side_b_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            depth_a_reg <= depth_a_next;
            depth_b_reg <= depth_b_next;
            side_b_reg  <= side_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            top_a_reg  <= top_a_next;
            top_b_reg  <= top_b_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
        else if (cmd.load_top)
        begin
            if (side_b_reg)
            begin
                top_b_reg <= rd_data_reg;
            end
            else
            begin
                top_a_reg <= rd_data_reg;
            end
        end
    end

    assign a_is_empty  = (depth_a_reg == '0);
    assign b_is_empty  = (depth_b_reg == '0);
    assign top_a_value = a_is_empty ? '0 : top_a_reg;
    assign top_b_value = b_is_empty ? '0 : top_b_reg;
    assign free_full   = CNT_W'(CAPACITY) - depth_a_reg - depth_b_reg;

    always_comb
    begin
        if (32'(free_full) > 32'(FREE_MAX))
        begin
            free_space = FREE_W'(FREE_MAX);
        end
        else
        begin
            free_space = FREE_W'(free_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {(OUT_W - OUT_USED)'(0), free_space, b_is_empty, a_is_empty,
                            top_b_value, top_a_value, popped_reg, status_reg};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign stat.pop_read = pop_read;
    assign stat.out_free = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(depth_a_reg) + SUM_W'(depth_b_reg)) <= SUM_W'(CAPACITY))
        else $error("stack depths exceed capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && op_in == OP_PUSH_A && !full) |=> (top_a_reg == $past(push_value)))
        else $error("top of A not updated on push");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_top |-> ($past(cmd.exec) && $past(pop_read)))
        else $error("top reload without a preceding pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/dual_stack_shared_memory.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A push or a refused operation runs from the input transaction through the
// response state to m_tvalid; a pop that leaves entries behind passes the load
// state first, where the registered read refetches the new top word. s_tready
// stays low until the result is loaded, which waits while the output stalls.
// Reset clears both depth counters and the handshake state; the array keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two LIFO stacks in one word array, A growing up from address zero and B
// growing down from the top address.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory
    import dssm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // op[1:0], push_value[33:2], zero pad
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // status[1:0], popped_value[33:2],
                                             // top_a_value[65:34], top_b_value[97:66],
                                             // a_is_empty[98], b_is_empty[99],
                                             // free_space[106:100], zero pad
);

    dssm_cmd_t  cmd;
    dssm_stat_t stat;

    dssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dssm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire

// ===== tb/dssm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_checker
// Watches both stream channels of the dual stack block. Every input
// transaction is run through a local model of the two stacks. Each result
// transaction is compared field by field against the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module dssm_checker
    import dssm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,     // op[1:0], push_value[33:2], zero pad
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,     // status[1:0], popped_value[33:2],
                                          // top_a_value[65:34], top_b_value[97:66],
                                          // a_is_empty[98], b_is_empty[99],
                                          // free_space[106:100], zero pad
    output int               errors,
    output int               outstanding
);

    typedef struct packed {
        dssm_status_t      status;
        logic [WORD_W-1:0] popped;
        logic [WORD_W-1:0] top_a;
        logic [WORD_W-1:0] top_b;
        logic              a_empty;
        logic              b_empty;
        logic [FREE_W-1:0] free_space;
    } stack_result_t;

    logic [WORD_W-1:0] stack_mem [0:CAPACITY-1];
    int                depth_a;
    int                depth_b;
    stack_result_t     pending_results [$];
    stack_result_t     want;
    stack_result_t     got;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] seen,
                                   input logic [WORD_W-1:0] wanted);
        $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what,
                 seen, wanted);
        errors++;
    endtask

    task automatic predict_stack_op(input dssm_op_t op, input logic [WORD_W-1:0] value,
                                    output stack_result_t r);
        int   free_cnt;
        logic full;
        r        = '0;
        r.status = ST_DONE;
        full     = (depth_a + depth_b) >= CAPACITY;
        case (op)
            OP_PUSH_A:
            begin
                if (full)
                    r.status = ST_OVERFLOW;
                else
                begin
                    stack_mem[depth_a] = value;
                    depth_a++;
                end
            end
            OP_PUSH_B:
            begin
                if (full)
                    r.status = ST_OVERFLOW;
                else
                begin
                    depth_b++;
                    stack_mem[CAPACITY - depth_b] = value;
                end
            end
            OP_POP_A:
            begin
                if (depth_a == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = stack_mem[depth_a - 1];
                    depth_a--;
                end
            end
            default:
            begin
                if (depth_b == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = stack_mem[CAPACITY - depth_b];
                    depth_b--;
                end
            end
        endcase
        // only live entries are read, so untouched words never leak out
        r.top_a   = (depth_a != 0) ? stack_mem[depth_a - 1] : '0;
        r.top_b   = (depth_b != 0) ? stack_mem[CAPACITY - depth_b] : '0;
        r.a_empty = (depth_a == 0);
        r.b_empty = (depth_b == 0);
        free_cnt  = CAPACITY - depth_a - depth_b;
        if (free_cnt > FREE_MAX)
            free_cnt = FREE_MAX;
        r.free_space = free_cnt[FREE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_a     = 0;
            depth_b     = 0;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_stack_op(dssm_op_t'(s_tdata[1:0]), s_tdata[33:2], want);
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.status     = dssm_status_t'(m_tdata[1:0]);
                got.popped     = m_tdata[33:2];
                got.top_a      = m_tdata[65:34];
                got.top_b      = m_tdata[97:66];
                got.a_empty    = m_tdata[98];
                got.b_empty    = m_tdata[99];
                got.free_space = m_tdata[106:100];
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[33:2], '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", WORD_W'(got.status),
                                        WORD_W'(want.status));
                    if (got.popped !== want.popped)
                        report_mismatch("popped_value", got.popped, want.popped);
                    if (got.top_a !== want.top_a)
                        report_mismatch("top_a_value", got.top_a, want.top_a);
                    if (got.top_b !== want.top_b)
                        report_mismatch("top_b_value", got.top_b, want.top_b);
                    if (got.a_empty !== want.a_empty)
                        report_mismatch("a_is_empty", WORD_W'(got.a_empty),
                                        WORD_W'(want.a_empty));
                    if (got.b_empty !== want.b_empty)
                        report_mismatch("b_is_empty", WORD_W'(got.b_empty),
                                        WORD_W'(want.b_empty));
                    if (got.free_space !== want.free_space)
                        report_mismatch("free_space", WORD_W'(got.free_space),
                                        WORD_W'(want.free_space));
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/dual_stack_shared_memory_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_test
// Drives push and pop transactions into the dual stack block: a directed
// opening on empty stacks and extreme words, then random segments that lean
// toward pushes or pops so both stacks fill until they meet and drain again.
// Sender bursts and receiver stalls are random; a side checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_test;
    import dssm_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SEG_ITEMS     = 75;
    localparam int NUM_SEGS      = 8;
    localparam int DRAIN_SEG     = 2;
    localparam int TAIL_CYCLES   = 10;

    localparam int RDY_ALWAYS    = 0;
    localparam int RDY_SPARSE    = 1;
    localparam int RDY_COIN      = 2;
    localparam int RDY_PERIODIC  = 3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;       // op[1:0], push_value[33:2], zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;            // status[1:0], popped_value[33:2],
                                          // top_a_value[65:34], top_b_value[97:66],
                                          // a_is_empty[98], b_is_empty[99],
                                          // free_space[106:100], zero pad
    int               errors;
    int               outstanding;
    int               cycle_count = 0;
    int               ready_mode = RDY_ALWAYS;
    int               ready_left = 0;

    int push_share [NUM_SEGS] = '{50, 90, 90, 10, 75, 25, 95, 5};

    dual_stack_shared_memory DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dssm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: pick a new stall pattern each time the current one runs out
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
            ready_left = $urandom_range(20, 150);
        end
        ready_left--;
        case (ready_mode)
            RDY_ALWAYS:   m_tready <= 1'b1;
            RDY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= (ready_left % 7 == 0);
        endcase
    end

    // hold valid until the transaction completes; returns on a falling edge
    task automatic send_op(input dssm_op_t op, input logic [WORD_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - WORD_W - 2){1'b0}}, value, op};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic hold_off(input int n);
        s_tvalid <= 1'b0;
        s_tdata  <= IN_W'({$urandom(), $urandom()});
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_random_op(input int push_pct);
        dssm_op_t op;
        logic     side_b;
        side_b = 1'($urandom_range(0, 1));
        if ($urandom_range(1, 100) <= push_pct)
            op = side_b ? OP_PUSH_B : OP_PUSH_A;
        else
            op = side_b ? OP_POP_B : OP_POP_A;
        send_op(op, $urandom());
    endtask

    initial
    begin
        int burst_left;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pops, extreme words on both sides, then unwind past empty
        send_op(OP_POP_A, 32'h1234_5678);
        send_op(OP_POP_B, 32'hFFFF_FFFF);
        send_op(OP_PUSH_A, 32'h7FFF_FFFF);
        send_op(OP_PUSH_B, 32'h8000_0000);
        send_op(OP_PUSH_A, 32'h0000_0000);
        send_op(OP_PUSH_B, 32'hFFFF_FFFF);
        send_op(OP_PUSH_A, 32'h8000_0000);
        send_op(OP_PUSH_B, 32'h7FFF_FFFF);
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_B, 32'h0);
        hold_off(3);
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_PUSH_B, 32'h5555_5555);
        send_op(OP_PUSH_A, 32'hAAAA_AAAA);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_A, 32'h0);

        // segments lean to pushes or pops so the stacks meet and drain again
        burst_left = $urandom_range(1, 24);
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                send_random_op(push_share[seg]);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 2) != 0)
                        hold_off($urandom_range(1, 8));
                end
            end
            if (seg == DRAIN_SEG)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
